@@ rtl/rhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared constants and types for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhsv_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int HUE_BITS_DEF  = 16;

  localparam int COMP_W = 16;  // input component width
  localparam int HUE_W  = 16;  // hue port width
  localparam int SAT_W  = 20;  // saturation port width

  localparam logic signed [SAT_W-1:0] SAT_POS_MAX = {1'b0, {(SAT_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_NEG_MIN = {1'b1, {(SAT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_e;

endpackage

`default_nettype wire

@@ rtl/rgb_to_hsv_converter.sv @@
// A result strobes on valid_o once its transaction, after acceptance, has passed the
//   capture, max/min, delta, dividend, divider and output registers.
// Throughput: one pixel per cycle; busy_o stays low, the receiver cannot stall.
// Depth is set by the two restoring dividers, one quotient bit per stage.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pipelined RGB to HSV conversion of signed fixed point pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter #(
  parameter int FRAC_BITS = rhsv_pkg::FRAC_BITS_DEF,
  parameter int HUE_BITS  = rhsv_pkg::HUE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic signed [rhsv_pkg::COMP_W-1:0] red_i,
  input  wire logic signed [rhsv_pkg::COMP_W-1:0] green_i,
  input  wire logic signed [rhsv_pkg::COMP_W-1:0] blue_i,
  output logic                                   valid_o,
  output logic [rhsv_pkg::HUE_W-1:0]             hue_o,
  output logic signed [rhsv_pkg::SAT_W-1:0]      saturation_o,
  output logic signed [rhsv_pkg::COMP_W-1:0]     brightness_o,
  output logic                                   sat_clipped_o
);
  import rhsv_pkg::*;

  localparam int NDS = ((HUE_BITS > SAT_W) ? HUE_BITS : SAT_W) + 1;
  localparam int SW  = ((FRAC_BITS > SAT_W) ? FRAC_BITS : SAT_W) + COMP_W + 2;
  localparam int HW  = HUE_BITS + 21;
  localparam int DW  = 19;  // 6 * delta
  localparam int LAT = NDS + 5;

  assign busy_o = 1'b0;

  // ---------------- stage 1: capture ----------------
  logic                     s1_v_q;
  logic signed [COMP_W-1:0] s1_r_q, s1_g_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_r_q <= red_i;
      s1_g_q <= green_i;
      s1_b_q <= blue_i;
    end
  end

  // ---------------- stage 2: max / min ----------------
  logic                     s2_v_q;
  logic signed [COMP_W-1:0] s2_r_q, s2_g_q, s2_b_q, s2_mx_q, s2_mn_q;
  max_sel_e                 s2_sel_q;
  logic signed [COMP_W-1:0] mx_d, mn_d;
  max_sel_e                 sel_d;

  always_comb begin
    if (s1_r_q >= s1_g_q && s1_r_q >= s1_b_q) begin
      sel_d = SEL_RED;
      mx_d  = s1_r_q;
    end else if (s1_g_q >= s1_b_q) begin
      sel_d = SEL_GREEN;
      mx_d  = s1_g_q;
    end else begin
      sel_d = SEL_BLUE;
      mx_d  = s1_b_q;
    end
    mn_d = s1_r_q;
    if (s1_g_q < mn_d) mn_d = s1_g_q;
    if (s1_b_q < mn_d) mn_d = s1_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_r_q   <= s1_r_q;
    s2_g_q   <= s1_g_q;
    s2_b_q   <= s1_b_q;
    s2_mx_q  <= mx_d;
    s2_mn_q  <= mn_d;
    s2_sel_q <= sel_d;
  end

  // ---------------- stage 3: delta, differences, magnitude ----------------
  logic                     s3_v_q;
  logic [COMP_W-1:0]        s3_d_q, s3_mag_q;
  logic signed [COMP_W:0]   s3_dgb_q, s3_dbr_q, s3_drg_q;
  logic signed [COMP_W-1:0] s3_mx_q;
  max_sel_e                 s3_sel_q;
  logic signed [COMP_W:0]   delta_w;
  logic [COMP_W-1:0]        mag_d;

  assign delta_w = (COMP_W+1)'(s2_mx_q) - (COMP_W+1)'(s2_mn_q);
  assign mag_d   = s2_mx_q[COMP_W-1] ? (COMP_W)'(-s2_mx_q) : s2_mx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_d_q   <= delta_w[COMP_W-1:0];
    s3_mag_q <= mag_d;
    s3_dgb_q <= (COMP_W+1)'(s2_g_q) - (COMP_W+1)'(s2_b_q);
    s3_dbr_q <= (COMP_W+1)'(s2_b_q) - (COMP_W+1)'(s2_r_q);
    s3_drg_q <= (COMP_W+1)'(s2_r_q) - (COMP_W+1)'(s2_g_q);
    s3_mx_q  <= s2_mx_q;
    s3_sel_q <= s2_sel_q;
  end

  // ---------------- stage 4: hue sector and dividends ----------------
  logic                     dv_v_q    [NDS+1];
  logic [SW-1:0]            srem_q    [NDS+1];
  logic [COMP_W-1:0]        smag_q    [NDS+1];
  logic [SAT_W:0]           sq_q      [NDS+1];
  logic [HW-1:0]            hrem_q    [NDS+1];
  logic [DW-1:0]            hden_q    [NDS+1];
  logic [HUE_BITS:0]        hq_q      [NDS+1];
  logic signed [COMP_W-1:0] dmx_q     [NDS+1];
  logic                     gray_q    [NDS+1];
  logic                     mxzero_q  [NDS+1];
  logic                     mxneg_q   [NDS+1];

  logic [DW-1:0]            d6_w, d3_w;
  logic signed [DW:0]       n_w;
  logic [DW-1:0]            n_u;

  assign d6_w = (DW'(s3_d_q) << 2) + (DW'(s3_d_q) << 1);
  assign d3_w = (DW'(s3_d_q) << 1) + DW'(s3_d_q);

  always_comb begin
    case (s3_sel_q)
      SEL_RED: begin
        n_w = (DW+1)'(s3_dgb_q);
        if (n_w < 0) n_w = n_w + (DW+1)'(d6_w);
      end
      SEL_GREEN: n_w = ((DW+1)'(s3_d_q) << 1) + (DW+1)'(s3_dbr_q);
      SEL_BLUE:  n_w = ((DW+1)'(s3_d_q) << 2) + (DW+1)'(s3_drg_q);
      default:   n_w = '0;
    endcase
    n_u = n_w[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    srem_q[0]   <= (SW'(s3_d_q) << FRAC_BITS) + SW'(s3_mag_q >> 1);
    smag_q[0]   <= s3_mag_q;
    sq_q[0]     <= '0;
    hrem_q[0]   <= (HW'(n_u) << HUE_BITS) + HW'(d3_w);
    hden_q[0]   <= d6_w;
    hq_q[0]     <= '0;
    dmx_q[0]    <= s3_mx_q;
    gray_q[0]   <= (s3_d_q == '0);
    mxzero_q[0] <= (s3_mx_q == '0);
    mxneg_q[0]  <= s3_mx_q[COMP_W-1];
  end

  // ---------------- divider stages, one quotient bit each, MSB first ----------------
  for (genvar j = 0; j < NDS; j++) begin : g_div
    localparam int K = NDS - 1 - j;
    logic [SW-1:0]     srem_d;
    logic [SAT_W:0]    sq_d;
    logic [HW-1:0]     hrem_d;
    logic [HUE_BITS:0] hq_d;

    if (K <= SAT_W) begin : g_sat
      logic [SW-1:0] sdiv;
      assign sdiv = SW'(smag_q[j]) << K;
      always_comb begin
        srem_d = srem_q[j];
        sq_d   = sq_q[j];
        if (srem_q[j] >= sdiv) begin
          srem_d = srem_q[j] - sdiv;
          sq_d[K] = 1'b1;
        end
      end
    end else begin : g_sat_pass
      assign srem_d = srem_q[j];
      assign sq_d   = sq_q[j];
    end

    if (K <= HUE_BITS) begin : g_hue
      logic [HW-1:0] hdiv;
      assign hdiv = HW'(hden_q[j]) << K;
      always_comb begin
        hrem_d = hrem_q[j];
        hq_d   = hq_q[j];
        if (hrem_q[j] >= hdiv) begin
          hrem_d = hrem_q[j] - hdiv;
          hq_d[K] = 1'b1;
        end
      end
    end else begin : g_hue_pass
      assign hrem_d = hrem_q[j];
      assign hq_d   = hq_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      srem_q[j+1]   <= srem_d;
      smag_q[j+1]   <= smag_q[j];
      sq_q[j+1]     <= sq_d;
      hrem_q[j+1]   <= hrem_d;
      hden_q[j+1]   <= hden_q[j];
      hq_q[j+1]     <= hq_d;
      dmx_q[j+1]    <= dmx_q[j];
      gray_q[j+1]   <= gray_q[j];
      mxzero_q[j+1] <= mxzero_q[j];
      mxneg_q[j+1]  <= mxneg_q[j];
    end
  end

  // ---------------- output stage: wrap, sign, clip ----------------
  logic                    valid_q, clip_q;
  logic [HUE_W-1:0]        hue_q;
  logic signed [SAT_W-1:0] sat_q;
  logic signed [COMP_W-1:0] bright_q;

  logic [HUE_W-1:0]        hue_d;
  logic signed [SAT_W-1:0] sat_d;
  logic                    clip_d;
  logic [31:0]             hue_ext;
  logic [SAT_W:0]          sq_f;

  // a quotient of exactly one full turn wraps to zero by dropping the top bit
  assign hue_ext = 32'(hq_q[NDS][HUE_BITS-1:0]);
  assign sq_f    = sq_q[NDS];

  always_comb begin
    hue_d  = hue_ext[HUE_W-1:0];
    sat_d  = '0;
    clip_d = 1'b0;
    if (gray_q[NDS]) begin
      hue_d = '0;
    end else if (mxzero_q[NDS]) begin
      sat_d  = SAT_POS_MAX;
      clip_d = 1'b1;
    end else if (!mxneg_q[NDS]) begin
      if (sq_f[SAT_W] || sq_f[SAT_W-1]) begin
        sat_d  = SAT_POS_MAX;
        clip_d = 1'b1;
      end else begin
        sat_d = sq_f[SAT_W-1:0];
      end
    end else begin
      if (sq_f > (SAT_W+1)'(1 << (SAT_W-1))) begin
        sat_d  = SAT_NEG_MIN;
        clip_d = 1'b1;
      end else begin
        sat_d = -sq_f[SAT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_v_q[NDS];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q    <= hue_d;
    sat_q    <= sat_d;
    clip_q   <= clip_d;
    bright_q <= dmx_q[NDS];
  end

  assign valid_o       = valid_q;
  assign hue_o         = hue_q;
  assign saturation_o  = sat_q;
  assign brightness_o  = bright_q;
  assign sat_clipped_o = clip_q;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT valid_o)
    else $error("result missing after fixed latency");

  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && sat_clipped_o |-> saturation_o == SAT_POS_MAX || saturation_o == SAT_NEG_MIN)
    else $error("clipped saturation not at a limit");

  a_zero_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && brightness_o == '0 |-> saturation_o == '0 || sat_clipped_o)
    else $error("zero max gave unflagged nonzero saturation");

  a_sat_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !brightness_o[COMP_W-1] |-> !saturation_o[SAT_W-1])
    else $error("nonnegative max gave negative saturation");

endmodule

`default_nettype wire
